// File: src/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Included by each module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

// File: src/hfpp_pkg.sv
// Types, codes and the hex digit decoder for the hex word deframer.
// No dependencies; imported by hfpp_collect and hex_float_packet_parser.
`timescale 1ns / 1ps

package hfpp_pkg;

	localparam logic [7:0] START_CHAR = 8'h24;

	typedef enum logic [1:0] {
		PH_SEEK    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_FULL    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_START = 2'd1,
		ST_SHORT    = 2'd2
	} status_t;

	typedef struct packed {
		logic    hex;
		logic [3:0] val;
	} nib_t;

	// Handed from the collector to the drain side on the end-of-packet beat
	typedef struct packed {
		logic    done;
		logic    bank;
		status_t status;
	} burst_t;

	function automatic nib_t hex_nibble(input logic [7:0] c);
		nib_t r;
		r.hex = 1'b1;
		r.val = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.hex = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: src/hfpp_collect.sv
// Byte parser: start character search, digit accumulation and the two-bank word store.
// Depends on hfpp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hfpp_collect import hfpp_pkg::*; #(
	parameter int NUM_WORDS       = 6,
	parameter int DIGITS_PER_WORD = 8,
	localparam int IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
	localparam int SLOT_W = $clog2(NUM_WORDS + 1),
	localparam int DIG_W  = (DIGITS_PER_WORD > 1) ? $clog2(DIGITS_PER_WORD) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             end_of_packet,
	input  logic             rd_bank,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [31:0]      rd_word,
	output logic             rd_ok,
	output burst_t           burst
);

	phase_t             phase_q, ph_d;
	status_t            status_d;
	logic [DIG_W-1:0]   digit_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [31:0]        acc_q;
	logic               bad_q;
	logic               wr_bank_q;
	logic [NUM_WORDS-1:0] valid_q [2];
	logic [31:0]        store_q [2][NUM_WORDS];

	nib_t               nib;
	logic [31:0]        acc_new;
	logic               bad_new;
	logic               grp_done;
	logic               last_grp;
	logic               is_start;
	logic               in_collect;
	logic [IDX_W-1:0]   wr_idx;

	assign nib        = hex_nibble(data_byte);
	assign acc_new    = nib.hex ? {acc_q[27:0], nib.val} : acc_q;
	assign bad_new    = bad_q | ~nib.hex;
	assign grp_done   = (digit_q == DIG_W'(DIGITS_PER_WORD - 1));
	assign last_grp   = (slot_q == SLOT_W'(NUM_WORDS - 1));
	assign is_start   = (data_byte == START_CHAR);
	assign in_collect = (phase_q == PH_COLLECT);
	assign wr_idx     = slot_q[IDX_W-1:0];

	// next phase for this beat, before any end-of-packet return to seek
	always_comb begin
		ph_d = phase_q;
		unique case (phase_q)
			PH_SEEK:    if (is_start) ph_d = PH_COLLECT;
			PH_COLLECT: if (grp_done && last_grp) ph_d = PH_FULL;
			PH_FULL:    ph_d = PH_FULL;
			default:    ph_d = PH_SEEK;
		endcase
	end

	always_comb begin
		unique case (ph_d)
			PH_SEEK:    status_d = ST_NO_START;
			PH_COLLECT: status_d = ST_SHORT;
			PH_FULL:    status_d = ST_OK;
			default:    status_d = ST_NO_START;
		endcase
	end

	assign burst.done   = take & end_of_packet;
	assign burst.bank   = wr_bank_q;
	assign burst.status = status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEEK;
			digit_q   <= '0;
			slot_q    <= '0;
			acc_q     <= '0;
			bad_q     <= 1'b0;
			wr_bank_q <= 1'b0;
			valid_q[0] <= '0;
			valid_q[1] <= '0;
		end else if (take) begin
			if (phase_q == PH_SEEK && is_start) begin
				valid_q[wr_bank_q] <= '0;
			end
			if (in_collect && grp_done) begin
				valid_q[wr_bank_q][wr_idx] <= ~bad_new;
			end
			if (end_of_packet) begin
				// drain side owns this bank now; parse the next packet into the other
				phase_q   <= PH_SEEK;
				digit_q   <= '0;
				slot_q    <= '0;
				acc_q     <= '0;
				bad_q     <= 1'b0;
				wr_bank_q <= ~wr_bank_q;
			end else begin
				phase_q <= ph_d;
				if (phase_q == PH_SEEK) begin
					digit_q <= '0;
					slot_q  <= '0;
					acc_q   <= '0;
					bad_q   <= 1'b0;
				end else if (in_collect) begin
					if (grp_done) begin
						digit_q <= '0;
						slot_q  <= slot_q + SLOT_W'(1);
						acc_q   <= '0;
						bad_q   <= 1'b0;
					end else begin
						digit_q <= digit_q + DIG_W'(1);
						acc_q   <= acc_new;
						bad_q   <= bad_new;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_collect && grp_done) begin
			store_q[wr_bank_q][wr_idx] <= acc_new;
		end
	end

	assign rd_word = store_q[rd_bank][rd_idx];
	assign rd_ok   = valid_q[rd_bank][rd_idx];

	`ASSERT_IMPL(a_full_counts, clk, arst_n, phase_q == PH_FULL,
		slot_q == SLOT_W'(NUM_WORDS) && digit_q == '0)
	`ASSERT_NEXT(a_eop_reseek, clk, arst_n, burst.done, phase_q == PH_SEEK && slot_q == '0)
	`ASSERT_NEXT(a_eop_flip, clk, arst_n, burst.done, wr_bank_q != $past(wr_bank_q))

endmodule

// File: src/hex_float_packet_parser.sv
// Top level of the hex word deframer: input handshake, result drain and output register.
// Depends on hfpp_pkg, hfpp_collect and assert_macros.svh.
//
// Usage:
//   Input channel: one packet byte per beat (data_byte, end_of_packet) on in_valid/in_stall.
//   Bytes before the first '$' are skipped; the next NUM_WORDS*DIGITS_PER_WORD bytes form
//   NUM_WORDS groups of hex digits. The beat flagged end_of_packet closes the packet.
//   Output channel: NUM_WORDS result beats per packet on out_valid/out_stall, index order,
//   final_word set on the last. packet_status repeats in every beat of the burst.
//   Throughput: one input byte per cycle while in_stall is low. The word store has two
//   banks, so the next packet is parsed while the previous burst drains; in_stall rises
//   only for an end-of-packet beat that arrives while a burst is still being drained.
//   Drain: the end-of-packet beat starts the drain, which then loads the first result from
//   the single store read port into the output register; after that, one result per cycle
//   while out_stall is low.
//   Reset: arst_n clears the parser to the start-character search and drops out_valid.
//   A stalled result holds in the output register; the drain waits behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hex_float_packet_parser import hfpp_pkg::*; #(
	parameter int NUM_WORDS       = 6,
	parameter int DIGITS_PER_WORD = 8,
	localparam int IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             end_of_packet,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      word_value,
	output logic [IDX_W-1:0] word_index,
	output logic             word_ok,
	output logic [1:0]       packet_status,
	output logic             final_word
);

	logic             take;
	burst_t           burst;
	logic [31:0]      rd_word;
	logic             rd_ok;

	logic             busy_q;
	logic             rd_bank_q;
	logic [IDX_W-1:0] rd_idx_q;
	status_t          rd_status_q;
	logic             load;
	logic             rd_last;
	logic             ok_d;

	logic             out_valid_q;
	logic [31:0]      word_value_q;
	logic [IDX_W-1:0] word_index_q;
	logic             word_ok_q;
	status_t          status_q;
	logic             final_q;

	assign in_stall = busy_q & end_of_packet;
	assign take     = in_valid & ~in_stall;

	hfpp_collect #(
		.NUM_WORDS       (NUM_WORDS),
		.DIGITS_PER_WORD (DIGITS_PER_WORD)
	) u_collect (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.rd_bank       (rd_bank_q),
		.rd_idx        (rd_idx_q),
		.rd_word       (rd_word),
		.rd_ok         (rd_ok),
		.burst         (burst)
	);

	assign load    = busy_q & (~out_valid_q | ~out_stall);
	assign rd_last = (rd_idx_q == IDX_W'(NUM_WORDS - 1));
	assign ok_d    = (rd_status_q == ST_OK) & rd_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rd_bank_q   <= 1'b0;
			rd_idx_q    <= '0;
			rd_status_q <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (burst.done) begin
				busy_q      <= 1'b1;
				rd_bank_q   <= burst.bank;
				rd_idx_q    <= '0;
				rd_status_q <= burst.status;
			end else if (load) begin
				busy_q   <= ~rd_last;
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load) begin
			word_value_q <= ok_d ? rd_word : 32'h0;
			word_index_q <= rd_idx_q;
			word_ok_q    <= ok_d;
			status_q     <= rd_status_q;
			final_q      <= rd_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign word_value    = word_value_q;
	assign word_index    = word_index_q;
	assign word_ok       = word_ok_q;
	assign packet_status = status_q;
	assign final_word    = final_q;

	`ASSERT_NEXT(a_burst_start, clk, arst_n, burst.done, busy_q && rd_idx_q == '0)
	`ASSERT_IMPL(a_ok_needs_status, clk, arst_n, out_valid_q && word_ok_q, status_q == ST_OK)
	`ASSERT_NEXT(a_last_flagged, clk, arst_n, load && rd_last,
		out_valid_q && final_q && !busy_q)

endmodule
